/* rtl/ufr_pkg.sv */
// ufr_pkg: shared types and constants of the update frame receiver
// frame geometry, register indexes, payload structs and controller states
// no dependencies; imported by update_frame_receiver_core and the testbench
package ufr_pkg;

  // frame geometry
  localparam int PAYLOAD_BYTES = 256;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 2;
  localparam int WORDS         = PAYLOAD_BYTES / 4;
  localparam int POS_W         = $clog2(FRAME_BYTES);
  localparam int IDX_W         = (WORDS > 1) ? $clog2(WORDS) : 1;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TYPE   = 2'd1;
  localparam logic [7:0]             FRAME_TYPE_RESET = 8'd3;

  // result kinds
  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] flash_address;
    logic [31:0] word;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_RECV  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

/* rtl/ufr_ram.sv */
// ufr_ram: generic single-port-write, single-port-read synchronous ram
// read data is registered and updated only when re is high
// no dependencies
module ufr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/update_frame_receiver_core.sv */
// update_frame_receiver_core: firmware update frame receiver, top level
// receive bytes are taken while in_ready is high; the payload lives in a 64-word ram (ufr_ram)
// a good frame drains 64 words, each by a ram read then an output load, one read outstanding;
// the first word comes after the drain state and a ram read; a reject shows next cycle
// input is held off while draining; synchronous reset clears position, sum, offset, drain state,
// sets the configuration registers to their reset values, and leaves ram contents as is
module update_frame_receiver_core
  import ufr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  // configuration registers
  logic [31:0] base_address;
  logic [7:0]  frame_type;

  // frame state
  state_t           state;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       running_sum;
  logic             type_matched;
  logic [31:0]      write_offset;
  logic [23:0]      stage;

  // drain control
  logic [IDX_W-1:0] drain_idx;
  logic             rd_pending;

  // ram ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [31:0]      ram_rdata;

  // byte datapath
  logic             in_xfer;
  logic             at_check;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       sum_eff;
  logic [7:0]       sum_next;
  logic [POS_W-1:0] pay_idx;
  logic [POS_W-1:0] word_sel;
  logic [1:0]       lane;
  logic             is_check;
  logic             frame_ok;
  logic             issue;
  logic             drain_last;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      frame_type   <= FRAME_TYPE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_FRAME_TYPE:   frame_type   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input side: hold off while draining, and a checksum byte while the output register is busy
  assign at_check = (byte_position >= POS_W'(FRAME_BYTES - 1));
  assign in_ready = (state == ST_RECV) && !(out_valid && at_check);
  assign in_xfer  = in_valid && in_ready;

  // position and sum after an optional restart
  assign pos_eff  = in_data.restart ? '0 : byte_position;
  assign sum_eff  = in_data.restart ? '0 : running_sum;
  assign sum_next = sum_eff + in_data.rx_byte;
  assign is_check = (pos_eff >= POS_W'(FRAME_BYTES - 1));
  assign frame_ok = type_matched && !in_data.restart && (running_sum == in_data.rx_byte);
  assign pay_idx  = pos_eff - POS_W'(1);
  assign word_sel = pay_idx >> 2;
  assign lane     = pay_idx[1:0];

  // full word written to the ram when its fourth byte arrives
  assign ram_we    = in_xfer && !is_check && (pos_eff != '0) && (lane == 2'd3)
                     && (word_sel < POS_W'(WORDS));
  assign ram_waddr = word_sel[IDX_W-1:0];
  assign ram_wdata = {in_data.rx_byte, stage};

  // drain read issue: one outstanding read, output register free at load time
  assign issue      = (state == ST_DRAIN) && !rd_pending && (!out_valid || out_ready);
  assign ram_re     = issue;
  assign drain_last = (drain_idx == IDX_W'(WORDS - 1));

  ufr_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (drain_idx),
    .rdata (ram_rdata)
  );

  // byte staging for the word under assembly
  always_ff @(posedge clk) begin
    if (in_xfer && !is_check && (pos_eff != '0)) begin
      case (lane)
        2'd0:    stage[7:0]   <= in_data.rx_byte;
        2'd1:    stage[15:8]  <= in_data.rx_byte;
        2'd2:    stage[23:16] <= in_data.rx_byte;
        default: ;
      endcase
    end
  end

  // frame tracking, drain sequencing and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RECV;
      byte_position <= '0;
      running_sum   <= '0;
      type_matched  <= 1'b0;
      write_offset  <= '0;
      drain_idx     <= '0;
      rd_pending    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // output transfer frees the register unless reloaded below
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // received byte
      if (in_xfer) begin
        if (is_check) begin
          byte_position <= '0;
          running_sum   <= '0;
          type_matched  <= 1'b0;
          if (frame_ok) begin
            state     <= ST_DRAIN;
            drain_idx <= '0;
          end else begin
            out_valid              <= 1'b1;
            out_data.kind          <= KIND_REJECT;
            out_data.flash_address <= '0;
            out_data.word          <= '0;
            out_data.last          <= 1'b1;
          end
        end else begin
          if (pos_eff == '0) begin
            type_matched <= (in_data.rx_byte == frame_type);
          end else if (in_data.restart) begin
            type_matched <= 1'b0;
          end
          running_sum   <= sum_next;
          byte_position <= pos_eff + POS_W'(1);
        end
      end

      // drain: issue a read, then load the word into the output register
      if (issue) begin
        rd_pending <= 1'b1;
      end
      if (rd_pending) begin
        rd_pending             <= 1'b0;
        out_valid              <= 1'b1;
        out_data.kind          <= KIND_WORD;
        out_data.flash_address <= base_address + write_offset;
        out_data.word          <= ram_rdata;
        out_data.last          <= drain_last;
        write_offset           <= write_offset + 32'd4;
        if (drain_last) begin
          state <= ST_RECV;
        end else begin
          drain_idx <= drain_idx + IDX_W'(1);
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for update_frame_receiver_core
// tracks frame position, checksum and payload, and checks the programmed words and rejects
// depends on ufr_pkg and update_frame_receiver_core
module testbench;
  import ufr_pkg::*;

  localparam int HOLD_CYCLES   = 700;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 500;
  localparam int RANDOM_FRAMES = 6;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_RAMP} fill_t;
  typedef enum int {SEQ_GOOD, SEQ_BAD_SUM, SEQ_BAD_TYPE, SEQ_CUT, SEQ_NOISE} seq_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data  = '0;

  // bytes waiting to be offered, and the words and rejects still owed by the block
  in_item_t  pending_bytes[$];
  out_item_t flash_writes_due[$];
  int        items_queued = 0;
  int        items_taken  = 0;
  int        mismatches   = 0;

  // shadow registers and frame tracking state
  logic [31:0] cfg_base   = '0;
  logic [7:0]  cfg_type   = FRAME_TYPE_RESET;
  logic [8:0]  frame_pos  = '0;
  logic [7:0]  frame_sum  = '0;
  logic        type_ok    = 1'b0;
  logic [31:0] payload_buf [WORDS];
  logic [31:0] wr_offset  = '0;

  // idling controls and counters; the enables and hold requests are set by the stimulus process
  logic send_idle_on = 1'b0;
  logic take_idle_on = 1'b0;
  int   send_wait    = 0;
  int   take_wait    = 0;
  int   stall_draw   = 0;
  int   hold_req     = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  logic aligned      = 1'b1;

  update_frame_receiver_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch: %s", what);
    end
  endtask

  // advance the frame tracker by one received byte, queueing any words or reject it causes
  task automatic track_frame_byte(input in_item_t it);
    out_item_t r;
    int        idx;
    if (it.restart) begin
      frame_pos = '0;
      frame_sum = '0;
      type_ok   = 1'b0;
    end
    if (frame_pos >= FRAME_BYTES - 1) begin
      if (type_ok && frame_sum == it.rx_byte) begin
        for (int k = 0; k < WORDS; k++) begin
          r.kind          = KIND_WORD;
          r.flash_address = cfg_base + wr_offset;
          r.word          = payload_buf[k];
          r.last          = (k == WORDS - 1);
          flash_writes_due.push_back(r);
          wr_offset = wr_offset + 32'd4;
        end
      end else begin
        r.kind          = KIND_REJECT;
        r.flash_address = '0;
        r.word          = '0;
        r.last          = 1'b1;
        flash_writes_due.push_back(r);
      end
      frame_pos = '0;
      frame_sum = '0;
      type_ok   = 1'b0;
    end else begin
      if (frame_pos == 0) begin
        type_ok = (it.rx_byte == cfg_type);
      end else begin
        idx = frame_pos - 1;
        payload_buf[idx / 4][(idx % 4) * 8 +: 8] = it.rx_byte;
      end
      frame_sum = frame_sum + it.rx_byte;
      frame_pos = frame_pos + 9'd1;
    end
  endtask

  // sender: one byte transfer per handshake, random gap after each offered byte when send idling is on
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        track_frame_byte(in_data);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid  <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_data   <= pending_bytes.pop_front();
          in_valid  <= 1'b1;
          send_wait <= send_idle_on ? int'($urandom_range(0, 12)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold-off on request, else a random stall after each result transfer when take idling is on
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      take_wait <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (out_valid && out_ready) begin
      stall_draw = take_idle_on ? int'($urandom_range(0, 12)) : 0;
      take_wait <= stall_draw;
      out_ready <= (stall_draw == 0);
    end else if (take_wait != 0) begin
      take_wait <= take_wait - 1;
      out_ready <= (take_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: compare each result transfer with the oldest owed one
  always @(posedge clk) begin
    out_item_t due;
    if (!rst && out_valid && out_ready) begin
      if (flash_writes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%b addr=%h word=%h last=%b",
                                out_data.kind, out_data.flash_address, out_data.word,
                                out_data.last));
      end else begin
        due = flash_writes_due.pop_front();
        if (out_data.kind !== due.kind)
          flag_mismatch($sformatf("kind %b, want %b", out_data.kind, due.kind));
        if (out_data.flash_address !== due.flash_address)
          flag_mismatch($sformatf("flash_address %h, want %h",
                                  out_data.flash_address, due.flash_address));
        if (out_data.word !== due.word)
          flag_mismatch($sformatf("word %h, want %h", out_data.word, due.word));
        if (out_data.last !== due.last)
          flag_mismatch($sformatf("last %b, want %b", out_data.last, due.last));
      end
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic rs);
    in_item_t it;
    it.rx_byte = b;
    it.restart = rs;
    pending_bytes.push_back(it);
    items_queued++;
  endtask

  // type byte, payload, checksum; a bad checksum is flipped by a nonzero mask
  task automatic queue_frame(input logic [7:0] type_byte, input fill_t fill,
                             input logic bad_sum, input logic lead_restart);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] mask;
    sum = type_byte;
    offer_byte(type_byte, lead_restart);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        FILL_RAMP: b = 8'(i % 256);
        default:   b = 8'($urandom_range(0, 255));
      endcase
      offer_byte(b, 1'b0);
      sum = sum + b;
    end
    mask = 8'($urandom_range(1, 255));
    offer_byte(bad_sum ? (sum ^ mask) : sum, 1'b0);
    aligned = 1'b1;
  endtask

  // partial frame of random bytes; optional random restarts make it noise
  task automatic queue_fragment(input int len, input logic lead_restart, input logic noisy);
    for (int i = 0; i < len; i++) begin
      offer_byte(8'($urandom_range(0, 255)),
                 (i == 0) ? lead_restart : (noisy && $urandom_range(0, 3) == 0));
    end
    aligned = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_BASE_ADDRESS) cfg_base = val;
    else if (idx == REG_FRAME_TYPE) cfg_type = val[7:0];
  endtask

  // sender pause until every byte is taken and every owed result has come
  task automatic wait_drained;
    while (items_taken != items_queued || flash_writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // timeout guard
  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int         start_items;
    int         frames_done;
    int         pick;
    int         guard;
    logic [7:0] wrong_type;
    logic [7:0] mask;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset-like settings, directed frames with no idling
    write_register(REG_BASE_ADDRESS, 32'h0000_0000);
    write_register(REG_FRAME_TYPE, 32'(FRAME_TYPE_RESET));
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'h03, 1'b1);
    aligned = 1'b0;
    queue_frame(cfg_type, FILL_ONES, 1'b0, 1'b1);
    queue_frame(cfg_type, FILL_ZERO, 1'b0, 1'b0);
    queue_frame(cfg_type, FILL_RAMP, 1'b1, 1'b0);
    queue_frame(8'hFF, FILL_RANDOM, 1'b0, 1'b1);
    // restart lands on the checksum slot
    queue_fragment(FRAME_BYTES - 1, 1'b1, 1'b0);
    queue_frame(cfg_type, FILL_RAMP, 1'b0, 1'b1);
    wait_drained();

    // address sum wraps past 32 bits, zero type, with idling on both sides
    send_idle_on = 1'b1;
    take_idle_on = 1'b1;
    write_register(REG_BASE_ADDRESS, 32'hFFFF_FF00);
    write_register(REG_FRAME_TYPE, 32'h0000_0000);
    queue_frame(8'h00, FILL_RANDOM, 1'b0, 1'b1);
    queue_frame(8'h01, FILL_RANDOM, 1'b0, 1'b0);
    wait_drained();

    write_register(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
    write_register(REG_FRAME_TYPE, 32'h0000_00FF);
    queue_frame(8'hFF, FILL_RANDOM, 1'b0, 1'b0);
    queue_frame(8'hFE, FILL_RANDOM, 1'b1, 1'b0);
    wait_drained();

    // receiver holds off while the first of two good frames streams in, so its drain backs up the input
    send_idle_on = 1'b0;
    take_idle_on = 1'b0;
    write_register(REG_BASE_ADDRESS, 32'h0800_0000);
    hold_req++;
    queue_frame(cfg_type, FILL_RANDOM, 1'b0, 1'b1);
    queue_frame(cfg_type, FILL_RANDOM, 1'b0, 1'b0);
    wait_drained();

    // random sequences, mostly well-formed frames with random content
    start_items = items_queued;
    frames_done = 0;
    while (items_queued - start_items < RANDOM_ITEMS || frames_done < RANDOM_FRAMES) begin
      send_idle_on = ($urandom_range(0, 2) != 0);
      take_idle_on = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      mask = 8'($urandom_range(1, 255));
      wrong_type = cfg_type ^ mask;
      if (pick < 55) begin
        queue_frame(cfg_type, FILL_RANDOM, 1'b0, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
        frames_done++;
      end else if (pick < 65) begin
        queue_frame(cfg_type, FILL_RANDOM, 1'b1, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
        frames_done++;
      end else if (pick < 75) begin
        queue_frame(wrong_type, FILL_RANDOM, 1'($urandom_range(0, 1)), 1'b1);
        frames_done++;
      end else if (pick < 87) begin
        queue_fragment($urandom_range(1, FRAME_BYTES - 1), 1'b1, 1'b0);
      end else begin
        queue_fragment($urandom_range(1, 20), 1'($urandom_range(0, 1)), 1'b1);
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 3))
            0:       write_register(REG_BASE_ADDRESS, 32'h0000_0000);
            1:       write_register(REG_BASE_ADDRESS, 32'hFFFF_FFF0);
            default: write_register(REG_BASE_ADDRESS, $urandom);
          endcase
          write_register(REG_FRAME_TYPE, $urandom_range(0, 255));
        end
      end
    end

    // let everything drain, bounded
    while (items_taken != items_queued) @(posedge clk);
    guard = 0;
    while (flash_writes_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (flash_writes_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", flash_writes_due.size()));

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ufr_pkg.sv
rtl/ufr_ram.sv
rtl/update_frame_receiver_core.sv
tb/testbench.sv
